/* hw/rtl/first_fit_heap_allocator_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit allocator.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// implication checked every edge outside reset
`define FFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the next edge
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;
    localparam int unsigned ArenaWordsDef = 4096;
    localparam int unsigned LinkW = 13;
    localparam int unsigned IdxW  = 12;
    localparam logic [12:0] LimitReset = 13'd4096;
    localparam logic [15:0] MinBytes = 16'd14;
    localparam logic [15:0] MaxBytes = 16'd32762;
    localparam logic [11:0] GrowWords = 12'd17;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SIZE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_BIG     = 3'd2,
        ST_NOMEM   = 3'd3,
        ST_CORRUPT = 3'd4
    } t_status;

    typedef struct packed {
        logic        we;
        logic [11:0] waddr;
        logic [12:0] wdata;
        logic        re;
        logic [11:0] raddr;
    } t_mem_req;
endpackage

/* hw/rtl/ffa_link_mem.sv */
// ----------------------------------------------------------------------------
// ffa_link_mem
// Link word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffa_link_mem #(
    parameter int unsigned ARENA_WORDS = ffa_pkg::ArenaWordsDef
) (
    input  logic              i_clk,
    input  ffa_pkg::t_mem_req i_req,
    output logic [12:0]       o_rdata
);
    import ffa_pkg::*;
    localparam int unsigned Depth = (ARENA_WORDS > 4096) ? 4096 : ARENA_WORDS;
    localparam int unsigned AW = $clog2(Depth);

    logic [12:0] r_mem [Depth];
    logic        r_oob;
    logic [12:0] r_q;
    logic [11:0] w_raddr, w_waddr;

    assign w_raddr = i_req.raddr;
    assign w_waddr = i_req.waddr;

    always_ff @(posedge i_clk) begin
        if (i_req.we && (32'(w_waddr) < Depth)) begin
            r_mem[w_waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q   <= r_mem[w_raddr[AW-1:0]];
            r_oob <= (32'(w_raddr) >= Depth);
        end
    end

    assign o_rdata = r_oob ? 13'd0 : r_q;
endmodule

/* hw/rtl/ffa_walker.sv */
// ----------------------------------------------------------------------------
// ffa_walker
// Command sequencer: walks, merges, splits and grows the block chain.
// ----------------------------------------------------------------------------
module ffa_walker #(
    parameter int unsigned ARENA_WORDS = ffa_pkg::ArenaWordsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_cmd,
    input  logic [15:0]       i_bytes,
    input  logic [11:0]       i_bidx,
    input  logic [12:0]       i_limit,
    input  logic [12:0]       i_rdata,
    output ffa_pkg::t_mem_req o_req,
    output logic              o_busy,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [11:0]       o_result,
    output logic [12:0]       o_usable
);
    import ffa_pkg::*;
    localparam int unsigned StepLimit = 8 * ARENA_WORDS + 64;
    localparam int unsigned StepW = $clog2(StepLimit + 2);
    localparam logic [12:0] CapP = (ARENA_WORDS > 4096) ? 13'd4096 : 13'(ARENA_WORDS);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_RDP, S_CHKP, S_RDQ, S_CHKQ, S_GROW1, S_GROW2, S_GROW3,
        S_SPLIT, S_FREE_RD, S_FREE_WR, S_SIZE_RD, S_SIZE_CHK, S_DONE
    } t_state;

    t_state      r_state;
    logic [12:0] r_top, r_p, r_q, r_lp, r_cap;
    logic [14:0] r_nw, r_ntop;
    logic [StepW-1:0] r_steps;
    logic        r_wraps;
    logic [2:0]  r_status;
    logic [11:0] r_result;
    logic [12:0] r_usable;
    logic [15:0] r_bytes;
    t_mem_req    r_req;
    logic [12:0] w_nq, w_np;
    logic [15:0] w_clamp;

    assign w_nq = {1'b0, i_rdata[11:0]};
    assign w_np = {1'b0, r_lp[11:0]};
    assign w_clamp = (i_bytes < MinBytes) ? MinBytes : i_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= 13'd1;
            r_req   <= '0;
        end else begin
            r_req.we <= 1'b0;
            r_req.re <= 1'b0;
            // hold while the read is in flight
            if (!r_req.re) begin
                case (r_state)
                    S_IDLE: if (i_start) begin
                        r_status <= ST_OK;
                        r_result <= '0;
                        r_usable <= '0;
                        r_bytes  <= w_clamp;
                        r_cap    <= (i_limit > CapP) ? CapP : i_limit;
                        r_steps  <= '0;
                        r_wraps  <= 1'b0;
                        r_p      <= '0;
                        case (i_cmd)
                            CMD_ALLOC: begin
                                if (i_bytes == 16'd0) begin
                                    r_status <= ST_NULL;
                                    r_state  <= S_DONE;
                                end else if (w_clamp > MaxBytes) begin
                                    r_status <= ST_BIG;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SETUP;
                                end
                            end
                            CMD_FREE: begin
                                r_p     <= {1'b0, i_bidx - 12'd1};
                                r_state <= (i_bidx == '0) ? S_DONE : S_FREE_RD;
                            end
                            CMD_SIZE: begin
                                r_p     <= {1'b0, i_bidx - 12'd1};
                                r_state <= (i_bidx == '0) ? S_DONE : S_SIZE_RD;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                    S_SETUP: begin
                        r_nw    <= 15'((17'(r_bytes) + 17'd3) >> 1);
                        r_state <= S_RDP;
                    end
                    S_RDP: begin
                        if (32'(r_steps) + 1 > StepLimit) begin
                            r_status <= ST_CORRUPT;
                            r_state  <= S_DONE;
                        end else begin
                            r_steps   <= r_steps + 1'b1;
                            r_req.re  <= 1'b1;
                            r_req.raddr <= r_p[11:0];
                            r_state   <= S_CHKP;
                        end
                    end
                    S_CHKP: begin
                        r_lp <= i_rdata;
                        if (!i_rdata[12]) begin
                            if (w_nq <= r_p || w_nq > r_top) begin
                                r_status <= ST_CORRUPT;
                                r_state  <= S_DONE;
                            end else begin
                                r_q <= w_nq;
                                r_req.re <= 1'b1;
                                r_req.raddr <= w_nq[11:0];
                                r_state <= S_CHKQ;
                            end
                        end else begin
                            r_state <= S_RDQ;
                        end
                    end
                    S_CHKQ: begin
                        if (i_rdata[12]) begin
                            if (15'(r_q) >= 15'(r_p) + r_nw) begin
                                r_state <= S_SPLIT;
                            end else begin
                                r_state <= S_RDQ;
                            end
                        end else if (r_q >= r_top || 32'(r_steps) + 1 > StepLimit
                                     || w_nq <= r_p || w_nq > r_top) begin
                            r_status <= ST_CORRUPT;
                            r_state  <= S_DONE;
                        end else begin
                            r_steps <= r_steps + 1'b1;
                            r_req.we <= 1'b1;
                            r_req.waddr <= r_p[11:0];
                            r_req.wdata <= i_rdata;
                            r_lp <= i_rdata;
                            r_q <= w_nq;
                            r_req.re <= 1'b1;
                            r_req.raddr <= w_nq[11:0];
                        end
                    end
                    S_RDQ: begin
                        if (w_np > r_p) begin
                            if (w_np > r_top) begin
                                r_status <= ST_CORRUPT;
                                r_state  <= S_DONE;
                            end else begin
                                r_p <= w_np;
                                r_state <= S_RDP;
                            end
                        end else if (r_p != r_top || w_np != '0) begin
                            r_status <= ST_CORRUPT;
                            r_state  <= S_DONE;
                        end else begin
                            r_p <= '0;
                            if (r_wraps) begin
                                r_ntop  <= 15'(r_top) + ((r_nw < 15'(GrowWords)) ?
                                           15'(GrowWords) + 15'd1 : r_nw + 15'd1);
                                r_state <= S_GROW1;
                            end else begin
                                r_wraps <= 1'b1;
                                r_state <= S_RDP;
                            end
                        end
                    end
                    S_GROW1: begin
                        if (r_ntop >= 15'(r_cap)) begin
                            r_status <= ST_NOMEM;
                            r_state  <= S_DONE;
                        end else begin
                            r_req.we <= 1'b1;
                            r_req.waddr <= r_top[11:0];
                            r_req.wdata <= r_top + 13'd1;
                            r_state <= S_GROW2;
                        end
                    end
                    S_GROW2: begin
                        r_req.we <= 1'b1;
                        r_req.waddr <= 12'(r_top + 13'd1);
                        r_req.wdata <= r_ntop[12:0];
                        r_state <= S_GROW3;
                    end
                    S_GROW3: begin
                        r_req.we <= 1'b1;
                        r_req.waddr <= r_ntop[11:0];
                        r_req.wdata <= 13'h1000;
                        r_top <= r_ntop[12:0];
                        r_wraps <= 1'b0;
                        r_p <= '0;
                        r_state <= S_RDP;
                    end
                    S_SPLIT: begin
                        if (15'(r_q) > 15'(r_p) + r_nw) begin
                            r_req.we <= 1'b1;
                            r_req.waddr <= 12'(15'(r_p) + r_nw);
                            r_req.wdata <= r_lp;
                        end
                        r_state <= S_FREE_WR;
                        r_result <= 12'(r_p + 13'd1);
                        r_lp <= {1'b1, 12'(15'(r_p) + r_nw)};
                    end
                    S_FREE_RD: begin
                        r_req.re <= 1'b1;
                        r_req.raddr <= r_p[11:0];
                        r_state <= S_FREE_WR;
                    end
                    S_FREE_WR: begin
                        r_req.we <= 1'b1;
                        r_req.waddr <= r_p[11:0];
                        r_req.wdata <= (r_status == ST_OK && r_result != '0) ? r_lp
                                       : (i_rdata & 13'h0FFF);
                        r_state <= S_DONE;
                    end
                    S_SIZE_RD: begin
                        r_req.re <= 1'b1;
                        r_req.raddr <= r_p[11:0];
                        r_state <= S_SIZE_CHK;
                    end
                    S_SIZE_CHK: begin
                        if (w_nq > r_p) begin
                            r_usable <= 13'((w_nq - r_p) << 1);
                        end
                        r_state <= S_DONE;
                    end
                    S_DONE: r_state <= S_IDLE;
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_req    = r_req;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_status;
    assign o_result = r_result;
    assign o_usable = r_usable;
endmodule

/* hw/rtl/first_fit_heap_allocator_core.sv */
// Free and size query each read one link, then write or check it; allocate time
// grows with each busy and free chain link walked, each merge and each growth.
// A link read is registered by the walker and again by the link store.
// Throughput: one word at a time; the next is taken once the result is taken.
// Reset: synchronous, active low; then loads the two sentinel links.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator with coalescing over a link word arena.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_macros.svh"
module first_fit_heap_allocator_core #(
    parameter int unsigned ARENA_WORDS = ffa_pkg::ArenaWordsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_byte_count,
    input  logic [11:0] i_block_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [11:0] o_result_index,
    output logic [12:0] o_usable_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffa_pkg::*;

    logic [12:0] r_limit;
    logic [1:0]  r_init;
    logic        r_pend, r_ovalid;
    logic [2:0]  r_status;
    logic [11:0] r_res;
    logic [12:0] r_use;
    t_mem_req    w_wreq, w_mreq;
    logic [12:0] w_rdata;
    logic        w_busy, w_done, w_start;
    logic [2:0]  w_st;
    logic [11:0] w_res;
    logic [12:0] w_use;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {19'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_limit <= pwdata[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 2'd0;
        end else if (r_init != 2'd2) begin
            r_init <= r_init + 2'd1;
        end
    end

    always_comb begin
        w_mreq = w_wreq;
        if (r_init == 2'd0) begin
            w_mreq = '{we: 1'b1, waddr: 12'd0, wdata: 13'h1001, re: 1'b0, raddr: 12'd0};
        end else if (r_init == 2'd1) begin
            w_mreq = '{we: 1'b1, waddr: 12'd1, wdata: 13'h1000, re: 1'b0, raddr: 12'd0};
        end
    end

    assign o_ready = (r_init == 2'd2) && !w_busy && !r_pend;
    assign w_start = i_valid && o_ready;

    ffa_link_mem #(.ARENA_WORDS(ARENA_WORDS)) u_mem (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_rdata(w_rdata)
    );

    ffa_walker #(.ARENA_WORDS(ARENA_WORDS)) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (i_command),
        .i_bytes (i_byte_count),
        .i_bidx  (i_block_index),
        .i_limit (r_limit),
        .i_rdata (w_rdata),
        .o_req   (w_wreq),
        .o_busy  (w_busy),
        .o_done  (w_done),
        .o_status(w_st),
        .o_result(w_res),
        .o_usable(w_use)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_start) begin
                r_pend <= 1'b1;
            end
            if (w_done) begin
                r_ovalid <= 1'b1;
                r_status <= w_st;
                r_res    <= w_res;
                r_use    <= w_use;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
                r_pend   <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_result_index = r_res;
    assign o_usable_bytes = r_use;

    `FFA_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, w_busy, !o_ready)
    `FFA_ASSERT_IMP(a_valid_pend, i_clk, i_rst_n, o_valid, r_pend)
    `FFA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, w_busy)
endmodule

/* tb/sv/first_fit_heap_allocator_core_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_checker
// Watches the command and result channels and the register port, keeps its
// own copy of the link arena, predicts each result and compares it.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_checker
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_byte_count,
    input  logic [11:0] i_block_index,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_status,
    input  logic [11:0] o_result_index,
    input  logic [12:0] o_usable_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output logic [11:0] o_arena_top
);
    localparam int unsigned NumWords  = 4096;
    localparam int unsigned WalkLimit = 8 * NumWords + 64;
    localparam logic [2:0]  AddrLimit = 3'd0;
    localparam int unsigned BusyBit   = 32'h1000;

    typedef struct packed {
        t_status     status;
        logic [11:0] index;
        logic [12:0] usable;
    } t_outcome;

    logic [12:0]  link_mem [NumWords];
    int unsigned  top_word;
    int unsigned  limit_words;
    t_outcome     outcome_q [$];

    assign o_pending   = outcome_q.size();
    assign o_arena_top = top_word[11:0];

    function automatic int unsigned link_rd(int unsigned i);
        return (i < NumWords) ? int'(link_mem[i]) : 0;
    endfunction

    function automatic void link_wr(int unsigned i, int unsigned v);
        if (i < NumWords) link_mem[i] = v[12:0];
    endfunction

    function automatic t_status place_block(input logic [15:0] nbytes,
                                            output logic [11:0] res);
        int unsigned b, nw, p, q, l, lq, n, wraps, grow, ntop, steps, ns, cap;
        bit hit;
        res = '0;
        steps = 0;
        hit = 0;
        q = 0;
        cap = (limit_words > NumWords) ? NumWords : limit_words;
        if (nbytes == 0) return ST_NULL;
        b = nbytes;
        if (b < 14) b = 14;
        if (b > 32762) return ST_BIG;
        nw = (b + 3) / 2;
        p = 0;
        forever begin
            wraps = 0;
            forever begin
                steps++;
                if (steps > WalkLimit) return ST_CORRUPT;
                l = link_rd(p);
                if ((l & BusyBit) == 0) begin
                    q = l & 32'hFFF;
                    if (q <= p || q > top_word) return ST_CORRUPT;
                    forever begin
                        lq = link_rd(q);
                        if ((lq & BusyBit) != 0) break;
                        if (q >= top_word) return ST_CORRUPT;
                        steps++;
                        if (steps > WalkLimit) return ST_CORRUPT;
                        n = lq & 32'hFFF;
                        if (n <= p || n > top_word) return ST_CORRUPT;
                        link_wr(p, lq);
                        q = n;
                    end
                    if (q >= p + nw) begin
                        hit = 1;
                        break;
                    end
                end
                n = link_rd(p) & 32'hFFF;
                if (n > p) begin
                    if (n > top_word) return ST_CORRUPT;
                    p = n;
                end else if (p != top_word || n != 0) begin
                    return ST_CORRUPT;
                end else begin
                    p = 0;
                    wraps++;
                    if (wraps > 1) break;
                end
            end
            if (hit) break;
            grow = (nw < 17) ? 18 : nw + 1;
            ntop = top_word + grow;
            if (ntop >= cap) return ST_NOMEM;
            link_wr(top_word, top_word + 1);
            link_wr(top_word + 1, ntop);
            link_wr(ntop, BusyBit);
            top_word = ntop;
        end
        ns = p + nw;
        if (q > ns) link_wr(ns, link_rd(p));
        link_wr(p, BusyBit | (ns & 32'hFFF));
        res = 12'(p + 1);
        return ST_OK;
    endfunction

    function automatic t_outcome predict_word(t_cmd cmd, logic [15:0] nbytes,
                                              logic [11:0] bidx);
        t_outcome r;
        int unsigned p, n;
        r = '{status: ST_OK, index: '0, usable: '0};
        case (cmd)
            CMD_ALLOC: r.status = place_block(nbytes, r.index);
            CMD_FREE: begin
                if (bidx != 0) begin
                    p = bidx - 1;
                    link_wr(p, link_rd(p) & ~BusyBit);
                end
            end
            CMD_SIZE: begin
                if (bidx != 0) begin
                    p = bidx - 1;
                    n = link_rd(p) & 32'hFFF;
                    if (n > p) r.usable = 13'((n - p) * 2);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            foreach (link_mem[i]) link_mem[i] = '0;
            link_mem[0] = 13'h1001;
            link_mem[1] = 13'h1000;
            top_word = 1;
            limit_words = 4096;
            outcome_q.delete();
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == AddrLimit)
                limit_words = pwdata[12:0];
            if (i_valid && o_ready)
                outcome_q.push_back(predict_word(t_cmd'(i_command), i_byte_count,
                                                 i_block_index));
            if (o_valid && i_ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        o_fail_count++;
                    end
                    if (o_result_index !== want.index) begin
                        $error("result_index: expected %0d, got %0d", want.index,
                               o_result_index);
                        o_fail_count++;
                    end
                    if (o_usable_bytes !== want.usable) begin
                        $error("usable_bytes: expected %0d, got %0d", want.usable,
                               o_usable_bytes);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/first_fit_heap_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_tb
// Drives allocate, free and size query words through the allocator under
// random idling on both sides and several arena limits; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core_tb;
    import ffa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_NONE;
    logic [15:0] i_byte_count = '0;
    logic [11:0] i_block_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_result_index;
    logic [12:0] o_usable_bytes;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    logic [11:0] arena_top;
    bit          idle_en = 1'b1;
    bit          long_hold = 1'b0;
    logic [11:0] live_q [$];

    localparam logic [2:0] AddrLimit = 3'd0;

    first_fit_heap_allocator_core dut (.*);

    first_fit_heap_allocator_core_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_byte_count,
        .i_block_index, .o_valid, .i_ready, .o_status, .o_result_index,
        .o_usable_bytes, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending), .o_arena_top(arena_top)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver
    initial begin
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // harvest block indices for later free and size words
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready && o_status == ST_OK && o_result_index != 0) begin
            live_q.push_back(o_result_index);
            if (live_q.size() > 256) void'(live_q.pop_front());
        end
    end

    task automatic send_word(t_cmd cmd, logic [15:0] nbytes, logic [11:0] bidx);
        i_valid <= 1'b1;
        i_command <= cmd;
        i_byte_count <= nbytes;
        i_block_index <= bidx;
        @(posedge i_clk iff (o_ready && i_valid));
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [12:0] words);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrLimit;
        pwdata <= {19'd0, words};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_block();
        if (live_q.size() == 0) return 12'd1;
        return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    task automatic random_words(int count);
        int k, r;
        logic [15:0] nb;
        int at;
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 52) begin
                r = $urandom_range(0, 99);
                if (r < 70) nb = 16'($urandom_range(1, 64));
                else if (r < 90) nb = 16'($urandom_range(65, 600));
                else if (r < 98) nb = 16'($urandom_range(600, 4000));
                else nb = 16'($urandom);
                send_word(CMD_ALLOC, nb, 12'($urandom));
            end else if (r < 85) begin
                if (live_q.size() > 0) begin
                    at = $urandom_range(0, live_q.size() - 1);
                    send_word(CMD_FREE, 16'($urandom), live_q[at]);
                    if ($urandom_range(0, 3) != 0) live_q.delete(at);
                end else begin
                    send_word(CMD_FREE, 16'($urandom), 12'd0);
                end
            end else if (r < 97) begin
                send_word(CMD_SIZE, 16'($urandom), pick_block());
            end else begin
                send_word($urandom_range(0, 1) ? CMD_NONE : CMD_SIZE, 16'($urandom), 12'd0);
            end
        end
    endtask

    initial begin
        logic [11:0] blk;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        set_limit(13'd4096);
        send_word(CMD_ALLOC, 16'd0, 12'd0);
        send_word(CMD_ALLOC, 16'd1, 12'hFFF);
        send_word(CMD_ALLOC, 16'd13, 12'd0);
        send_word(CMD_ALLOC, 16'd14, 12'd0);
        send_word(CMD_ALLOC, 16'd15, 12'd0);
        send_word(CMD_ALLOC, 16'd32762, 12'd0);
        send_word(CMD_ALLOC, 16'd32763, 12'd0);
        send_word(CMD_ALLOC, 16'hFFFF, 12'd0);
        send_word(CMD_ALLOC, 16'd7000, 12'd0);
        send_word(CMD_FREE, 16'd0, 12'd0);
        send_word(CMD_SIZE, 16'hFFFF, 12'd0);
        send_word(CMD_NONE, 16'hFFFF, 12'hFFF);
        send_word(CMD_SIZE, 16'd0, 12'd1);
        drain();
        blk = pick_block();
        send_word(CMD_SIZE, 16'd0, blk);
        send_word(CMD_FREE, 16'd0, blk);
        send_word(CMD_ALLOC, 16'd14, 12'd0);
        send_word(CMD_ALLOC, 16'd100, 12'd0);
        send_word(CMD_FREE, 16'd0, 12'd1);
        send_word(CMD_ALLOC, 16'd20, 12'd0);
        send_word(CMD_SIZE, 16'd0, 12'd1);

        random_words(150);
        long_hold = 1'b1;
        random_words(5);
        drain();
        random_words(250);

        set_limit(13'd4);
        random_words(100);
        set_limit(13'd700);
        random_words(400);
        set_limit(13'd4096);
        random_words(450);
        idle_en = 1'b0;
        random_words(200);

        drain();
        send_word(CMD_FREE, 16'd0, arena_top + 12'd1);
        send_word(CMD_ALLOC, 16'd40, 12'd0);
        send_word(CMD_ALLOC, 16'd14, 12'd0);

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_link_mem.sv
hw/rtl/ffa_walker.sv
hw/rtl/first_fit_heap_allocator_core.sv
tb/sv/first_fit_heap_allocator_core_checker.sv
tb/sv/first_fit_heap_allocator_core_tb.sv
